FILE: rtl/core/sequential_list_engine_core_macros.svh
// Assertion shorthands shared by the list engine RTL.
// Every check is sampled on clk and disabled while rst_n is low.
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent
`define SLE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sle_pkg.sv
package sle_pkg;

  // Storage geometry
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  // Fixed field widths of the request and result channels
  localparam int FUNC_W    = 3;
  localparam int POS_W     = 7;
  localparam int IN_VAL_W  = 32;
  localparam int OUT_VAL_W = 32;
  localparam int STAT_W    = 2;

  // Stored element width: values are cut to DATA_WIDTH and to the 32-bit field
  localparam int VAL_W  = (DATA_WIDTH < IN_VAL_W) ? DATA_WIDTH : IN_VAL_W;
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  typedef logic [VAL_W-1:0] elem_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 3'd0,
    FN_GET    = 3'd1,
    FN_INSERT = 3'd2,
    FN_DELETE = 3'd3,
    FN_PRIOR  = 3'd4,
    FN_NEXT   = 3'd5,
    FN_LOCATE = 3'd6
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Where the result value comes from
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RD,
    SRC_PREV,
    SRC_GONE
  } res_src_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     clear;
    logic     init_idx;
    logic     rd_step;
    logic     move;
    logic     put;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     set_res;
    status_t  res_status;
    res_src_t res_src;
    logic     res_pos_take;
    logic     out_load;
  } sle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              pos_bad;
    logic              full;
    logic              at_end;
    logic              n_lt2;
    logic              n_zero;
    logic              rd_last;
    logic              hit;
    logic              pend_first;
    logic              pend_last;
  } sle_stat_t;

  function automatic logic [OUT_VAL_W-1:0] widen_val(input elem_t v);
    logic [OUT_VAL_W-1:0] r;
    r = '0;
    r[VAL_W-1:0] = v;
    return r;
  endfunction

  function automatic logic [POS_W-1:0] count_to_pos(input logic [CNT_W-1:0] c);
    logic [POS_W-1:0] r;
    r = '0;
    r[CNT_W-1:0] = c;
    return r;
  endfunction

endpackage

FILE: rtl/core/sle_in_if.sv
interface sle_in_if import sle_pkg::*;;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [POS_W-1:0]    position;
  logic [IN_VAL_W-1:0] item_value;

  modport source (output valid, output func, output position, output item_value,
                  input ready);
  modport sink (input valid, input func, input position, input item_value,
                output ready);
endinterface

FILE: rtl/core/sle_out_if.sv
interface sle_out_if import sle_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic [OUT_VAL_W-1:0] result_value;
  logic [POS_W-1:0]     result_position;
  logic [POS_W-1:0]     list_length;
  logic                 list_empty;

  modport source (output valid, output status, output result_value,
                  output result_position, output list_length, output list_empty,
                  input ready);
  modport sink (input valid, input status, input result_value,
                input result_position, input list_length, input list_empty,
                output ready);
endinterface

FILE: rtl/core/sequential_list_engine_core.sv
// Ordered list of up to CAPACITY values with get, insert, delete, prior, next,
// locate and clear; every request returns exactly one result carrying the new
// length and an empty flag. One request is in work at a time: clear and
// rejected requests go straight to the result, get reads one entry, insert
// shifts the tail up one place before the new value is written (no shift when
// appending), delete shifts the tail down, and prior, next and locate scan
// from the head until the first match or the end of the list. The element
// store has one read and one write port, so the tail shift and the searches
// move one entry per cycle. A new request is taken while the previous result
// still waits in the output register. The store needs no clearing after
// reset; only entries below the length are read.
`include "sequential_list_engine_core_macros.svh"

module sequential_list_engine_core import sle_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  sle_in_if.sink    in_chan,
  sle_out_if.source out_chan
);

  sle_cmd_t  cmd;
  sle_stat_t stat;

  // Handshake and result terms for the checks
  logic in_xfer;
  logic res_failed;
  logic res_value_zero;
  logic empty_ok;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sle_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .func            (in_chan.func),
    .position        (in_chan.position),
    .item_value      (in_chan.item_value),
    .cmd             (cmd),
    .stat            (stat),
    .status          (out_chan.status),
    .result_value    (out_chan.result_value),
    .result_position (out_chan.result_position),
    .list_length     (out_chan.list_length),
    .list_empty      (out_chan.list_empty)
  );

  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign res_failed     = out_chan.valid && (out_chan.status != ST_OK);
  assign res_value_zero = (out_chan.result_value == '0);
  assign empty_ok       = (out_chan.list_empty == (out_chan.list_length == '0));

  // Checks
  `SLE_ASSERT_SAME(a_put_not_full, cmd.put, !stat.full, "new element written into a full list")
  `SLE_ASSERT_NEXT(a_busy_after_in, in_xfer, !in_chan.ready, "second transfer taken while busy")
  `SLE_ASSERT_SAME(a_fail_zero_value, res_failed, res_value_zero, "value on a failed request")
  `SLE_ASSERT_SAME(a_empty_flag, out_chan.valid, empty_ok, "empty flag disagrees with length")

endmodule

FILE: rtl/core/sle_ram.sv
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/sle_ctrl.sv
module sle_ctrl import sle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sle_stat_t stat,
  output sle_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_GRAB,
    S_SHIFT,
    S_FLUSH,
    S_PUT,
    S_SCAN,
    S_SCAN_END,
    S_FIN
  } state_t;

  state_t   state_r, state_nxt;
  logic     out_valid_r, out_valid_nxt;

  // Outcome of a search match on the entry now coming out of the store
  status_t  hit_status;
  res_src_t hit_src;
  logic     hit_grab;

  always_comb begin
    hit_grab   = (stat.func == FN_NEXT) && !stat.pend_last;
    hit_status = ST_OK;
    if ((stat.func == FN_PRIOR && stat.pend_first) ||
        (stat.func == FN_NEXT && stat.pend_last)) begin
      hit_status = ST_MISS;
    end
    hit_src = (stat.func == FN_PRIOR && hit_status == ST_OK) ? SRC_PREV : SRC_ZERO;
  end

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res_status = ST_OK;
    cmd.res_src    = SRC_ZERO;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        cmd.init_idx = 1'b1;
        state_nxt    = S_FIN;
        unique case (stat.func) inside
          FN_CLEAR: begin
            cmd.clear   = 1'b1;
            cmd.set_res = 1'b1;
          end
          FN_GET: begin
            if (stat.pos_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISS;
            end else begin
              state_nxt = S_READ;
            end
          end
          FN_INSERT: begin
            if (stat.pos_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISS;
            end else if (stat.full) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_FULL;
            end else if (stat.at_end) begin
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          FN_DELETE: begin
            if (stat.pos_bad) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISS;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          FN_PRIOR, FN_NEXT: begin
            if (stat.n_lt2) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISS;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          FN_LOCATE: begin
            if (stat.n_zero) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_MISS;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_MISS;
          end
        endcase
      end

      S_READ: begin
        cmd.rd_step = 1'b1;
        state_nxt   = S_GRAB;
      end

      S_GRAB: begin
        cmd.set_res = 1'b1;
        cmd.res_src = SRC_RD;
        state_nxt   = S_FIN;
      end

      // Walk the tail one entry per cycle; each entry is written in the cycle after it is read
      S_SHIFT: begin
        cmd.rd_step = 1'b1;
        cmd.move    = 1'b1;
        if (stat.rd_last) begin
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        cmd.move = 1'b1;
        if (stat.func == FN_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_src = SRC_GONE;
          state_nxt   = S_FIN;
        end
      end

      S_PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_res = 1'b1;
        state_nxt   = S_FIN;
      end

      S_SCAN: begin
        cmd.rd_step = 1'b1;
        if (stat.hit) begin
          if (hit_grab) begin
            state_nxt = S_GRAB;
          end else begin
            cmd.set_res      = 1'b1;
            cmd.res_status   = hit_status;
            cmd.res_src      = hit_src;
            cmd.res_pos_take = (stat.func == FN_LOCATE);
            state_nxt        = S_FIN;
          end
        end else if (stat.rd_last) begin
          state_nxt = S_SCAN_END;
        end
      end

      // Last entry is coming out of the store
      S_SCAN_END: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_FIN;
        if (stat.hit) begin
          cmd.res_status   = hit_status;
          cmd.res_src      = hit_src;
          cmd.res_pos_take = (stat.func == FN_LOCATE);
        end else begin
          cmd.res_status = ST_MISS;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/sle_datapath.sv
module sle_datapath import sle_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [FUNC_W-1:0]    func,
  input  logic [POS_W-1:0]     position,
  input  logic [IN_VAL_W-1:0]  item_value,
  input  sle_cmd_t             cmd,
  output sle_stat_t            stat,
  output logic [STAT_W-1:0]    status,
  output logic [OUT_VAL_W-1:0] result_value,
  output logic [POS_W-1:0]     result_position,
  output logic [POS_W-1:0]     list_length,
  output logic                 list_empty
);

  // Request registers
  logic [FUNC_W-1:0] func_r;
  logic [POS_W-1:0]  pos_r;
  elem_t             val_r;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] pend_idx_r;
  logic              pend_r;
  elem_t             prev_r;
  elem_t             gone_r;

  // Result held until the output register is free
  logic [STAT_W-1:0] res_status_r;
  elem_t             res_value_r, res_value_nxt;
  logic [POS_W-1:0]  res_pos_r;

  // Output register
  logic [STAT_W-1:0] out_status_r;
  elem_t             out_value_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [POS_W-1:0]  out_len_r;
  logic              out_empty_r;

  logic [POS_W-1:0]  n_pos, pos_m1;
  logic [ADDR_W-1:0] addr_p, addr_n, idx_start, idx_stop;
  logic              is_scan, is_insert, is_delete;
  logic              gone_now;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  elem_t             wr_data;
  elem_t             rd_data;

  // Position checks and walk bounds
  always_comb begin
    n_pos     = count_to_pos(count_r);
    pos_m1    = pos_r - POS_W'(1);
    addr_p    = pos_m1[ADDR_W-1:0];
    addr_n    = ADDR_W'(count_r - CNT_W'(1));
    is_insert = (func_r == FN_INSERT);
    is_delete = (func_r == FN_DELETE);
    is_scan   = (func_r == FN_PRIOR) || (func_r == FN_NEXT) || (func_r == FN_LOCATE);
    idx_start = is_insert ? addr_n : (is_scan ? '0 : addr_p);
    idx_stop  = is_insert ? addr_p : addr_n;
  end

  always_comb begin
    stat.func       = func_r;
    stat.pos_bad    = (pos_r == '0) || (is_insert ? (pos_m1 > n_pos) : (pos_r > n_pos));
    stat.full       = (count_r == CNT_W'(CAPACITY));
    stat.at_end     = (pos_m1 == n_pos);
    stat.n_lt2      = (count_r < CNT_W'(2));
    stat.n_zero     = (count_r == '0);
    stat.rd_last    = (idx_r == idx_stop);
    stat.hit        = pend_r && (rd_data == val_r);
    stat.pend_first = (pend_idx_r == '0);
    stat.pend_last  = (pend_idx_r == addr_n);
  end

  // Store write: new element, or one step of the tail shift
  always_comb begin
    gone_now = cmd.move && pend_r && is_delete && (pend_idx_r == addr_p);
    wr_en    = 1'b0;
    wr_addr  = pend_idx_r;
    wr_data  = rd_data;
    if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = addr_p;
      wr_data = val_r;
    end else if (cmd.move && pend_r && !gone_now) begin
      wr_en   = 1'b1;
      wr_addr = is_insert ? (pend_idx_r + ADDR_W'(1)) : (pend_idx_r - ADDR_W'(1));
    end
  end

  sle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_step),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Walk index and length
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.init_idx) begin
      idx_nxt = idx_start;
    end else if (cmd.rd_step) begin
      idx_nxt = is_insert ? (idx_r - ADDR_W'(1)) : (idx_r + ADDR_W'(1));
    end

    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd.res_src)
      SRC_RD:   res_value_nxt = rd_data;
      SRC_PREV: res_value_nxt = prev_r;
      SRC_GONE: res_value_nxt = gone_now ? rd_data : gone_r;
      default:  res_value_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= cmd.rd_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      pos_r  <= position;
      val_r  <= item_value[VAL_W-1:0];
    end
    idx_r <= idx_nxt;
    if (cmd.rd_step) begin
      pend_idx_r <= idx_r;
    end
    // Keep the entry before the one being compared
    if (pend_r) begin
      prev_r <= rd_data;
    end
    if (gone_now) begin
      gone_r <= rd_data;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_value_r  <= res_value_nxt;
      res_pos_r    <= cmd.res_pos_take ? (POS_W'(pend_idx_r) + POS_W'(1)) : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
      out_pos_r    <= res_pos_r;
      out_len_r    <= n_pos;
      out_empty_r  <= (count_r == '0);
    end
  end

  assign status          = out_status_r;
  assign result_value    = widen_val(out_value_r);
  assign result_position = out_pos_r;
  assign list_length     = out_len_r;
  assign list_empty      = out_empty_r;

endmodule
